/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define SPQ_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* design/spq_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, entry type and index helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	// Ring index plus an offset below the depth, wrapped by one subtract.
	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
			s = s - (IDX_W+1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

/* design/spq_if.sv */
// ---------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready command and response channels with their payloads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             cmd;
	logic [KEY_BITS-1:0]    msg_key;
	logic [HANDLE_BITS-1:0] msg_handle;

	modport source (output valid, output cmd, output msg_key, output msg_handle,
		input ready);
	modport sink (input valid, input cmd, input msg_key, input msg_handle,
		output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic                   head_valid;
	logic [KEY_BITS-1:0]    head_key;
	logic [HANDLE_BITS-1:0] head_handle;
	logic [CNT_W-1:0]       entry_count;

	modport source (output valid, output status, output head_valid, output head_key,
		output head_handle, output entry_count, input ready);
	modport sink (input valid, input status, input head_valid, input head_key,
		input head_handle, input entry_count, output ready);
endinterface

/* design/sorted_priority_queue_unit.sv */
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of key and handle entries kept in ascending key order.
// ---------------------------------------------------------------------------
// Entries live in a ring memory with a registered read, indexed from a head
// pointer, and the head entry is mirrored in registers. One command is
// processed at a time. An insert walks the ring from the tail, reading one
// entry and writing it one slot higher per cycle while its key is larger.
// A finished response waits in an output register while the next command
// beat is taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sorted_priority_queue_unit import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		IDLE,
		WALK,
		PUT,
		POP_RD,
		DONE
	} state_t;

	state_t                 state_q;
	entry_t                 mem [QUEUE_DEPTH];
	entry_t                 mem_rdata_q;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [IDX_W-1:0]       mem_raddr;
	entry_t                 mem_wdata;

	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       walk_q;
	entry_t                 new_q;
	entry_t                 hd_q;
	entry_t                 pop_q;
	logic                   pop_ok_q;
	logic [1:0]             status_q;

	logic                   rsp_valid_q;
	logic [1:0]             rsp_status_q;
	logic                   rsp_head_valid_q;
	logic [KEY_BITS-1:0]    rsp_key_q;
	logic [HANDLE_BITS-1:0] rsp_handle_q;
	logic [CNT_W-1:0]       rsp_count_q;

	logic                   accept;
	logic                   is_full;
	logic                   is_empty;
	logic                   shift;
	logic [CNT_W-1:0]       cnt_dec;
	logic [CNT_W-1:0]       cnt_inc;
	entry_t                 in_ent;

	assign accept   = req.valid && req.ready;
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign shift    = (mem_rdata_q.key > new_q.key);
	assign cnt_dec  = count_q - CNT_W'(1);
	assign cnt_inc  = count_q + CNT_W'(1);
	assign in_ent   = '{key: req.msg_key, handle: req.msg_handle};

	assign req.ready       = (state_q == IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.head_valid  = rsp_head_valid_q;
	assign rsp.head_key    = rsp_key_q;
	assign rsp.head_handle = rsp_handle_q;
	assign rsp.entry_count = rsp_count_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = new_q;
		mem_raddr = head_q;
		unique case (state_q)
			IDLE: begin
				if (accept && req.cmd == CMD_INSERT && is_empty) begin
					mem_we    = 1'b1;
					mem_wdata = in_ent;
				end
				if (req.cmd == CMD_INSERT) begin
					mem_raddr = idx_add(head_q, cnt_dec[IDX_W-1:0]);
				end else begin
					mem_raddr = idx_add(head_q, IDX_W'(1));
				end
			end
			WALK: begin
				mem_we    = 1'b1;
				mem_waddr = idx_add(head_q, walk_q + IDX_W'(1));
				mem_wdata = shift ? mem_rdata_q : new_q;
				mem_raddr = idx_add(head_q, walk_q - IDX_W'(1));
			end
			PUT: begin
				mem_we = 1'b1;
			end
			POP_RD, DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= IDLE;
			head_q           <= '0;
			count_q          <= '0;
			walk_q           <= '0;
			new_q            <= '0;
			hd_q             <= '0;
			pop_q            <= '0;
			pop_ok_q         <= 1'b0;
			status_q         <= ST_OK;
			rsp_valid_q      <= 1'b0;
			rsp_status_q     <= ST_OK;
			rsp_head_valid_q <= 1'b0;
			rsp_key_q        <= '0;
			rsp_handle_q     <= '0;
			rsp_count_q      <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						new_q    <= in_ent;
						pop_ok_q <= 1'b0;
						status_q <= ST_OK;
						priority if (req.cmd == CMD_INSERT) begin
							if (is_full) begin
								status_q <= ST_FULL;
								state_q  <= DONE;
							end else if (is_empty) begin
								hd_q    <= in_ent;
								count_q <= cnt_inc;
								state_q <= DONE;
							end else begin
								walk_q  <= cnt_dec[IDX_W-1:0];
								state_q <= WALK;
							end
						end else if (is_empty) begin
							status_q <= ST_EMPTY;
							state_q  <= DONE;
						end else if (req.cmd == CMD_POP) begin
							pop_ok_q <= 1'b1;
							pop_q    <= hd_q;
							head_q   <= idx_add(head_q, IDX_W'(1));
							count_q  <= cnt_dec;
							state_q  <= (count_q == CNT_W'(1)) ? DONE : POP_RD;
						end else begin
							state_q <= DONE;
						end
					end
				end
				WALK: begin
					if (shift) begin
						if (walk_q == '0) begin
							state_q <= PUT;
						end else begin
							walk_q <= walk_q - IDX_W'(1);
						end
					end else begin
						count_q <= cnt_inc;
						state_q <= DONE;
					end
				end
				PUT: begin
					hd_q    <= new_q;
					count_q <= cnt_inc;
					state_q <= DONE;
				end
				POP_RD: begin
					hd_q    <= mem_rdata_q;
					state_q <= DONE;
				end
				DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q      <= 1'b1;
						rsp_status_q     <= status_q;
						rsp_head_valid_q <= !is_empty;
						rsp_count_q      <= count_q;
						if (pop_ok_q) begin
							rsp_key_q    <= pop_q.key;
							rsp_handle_q <= pop_q.handle;
						end else if (!is_empty) begin
							rsp_key_q    <= hd_q.key;
							rsp_handle_q <= hd_q.handle;
						end else begin
							rsp_key_q    <= '0;
							rsp_handle_q <= '0;
						end
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
	`SPQ_ASSERT(a_head_valid,
		rsp.valid |-> (rsp.head_valid == (rsp.entry_count != '0)),
		"head valid disagrees with count")
	`SPQ_ASSERT(a_full_count,
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_count == CNT_W'(QUEUE_DEPTH)),
		"full status below depth")
	`SPQ_NEVER(a_walk_overlap,
		state_q == WALK && mem_we && mem_waddr == mem_raddr,
		"walk write and read collide")

endmodule
